// File: rtl/stok_pkg.sv
// stok_pkg: shared types, character codes, token classes and decode functions
// for the source tokenizer. No dependencies; used by every stok_* module.
package stok_pkg;

    // default sizes
    localparam int WORD_BUF_DEF = 16;
    localparam int LINE_MAX_DEF = 1024;
    localparam int QDEPTH       = 4;
    localparam int ERR_MAX      = 16'hFFFF;

    localparam logic [47:0] MANT_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [5:0]  FRAC_MAX = 6'd63;

    // word kind flag bits
    localparam int FL_ID      = 0;
    localparam int FL_NUM     = 1;
    localparam int FL_DOT     = 2;
    localparam int FL_LASTDIG = 3;

    // character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    // token classes
    localparam logic [4:0] CLS_ERROR   = 5'd0;
    localparam logic [4:0] CLS_IDENT   = 5'd1;
    localparam logic [4:0] CLS_NUMBER  = 5'd2;
    localparam logic [4:0] CLS_PLUS    = 5'd3;
    localparam logic [4:0] CLS_MINUS   = 5'd4;
    localparam logic [4:0] CLS_TIMES   = 5'd5;
    localparam logic [4:0] CLS_SLASH   = 5'd6;
    localparam logic [4:0] CLS_ODD     = 5'd7;
    localparam logic [4:0] CLS_EQ      = 5'd8;
    localparam logic [4:0] CLS_HASH    = 5'd9;
    localparam logic [4:0] CLS_LT      = 5'd10;
    localparam logic [4:0] CLS_LE      = 5'd11;
    localparam logic [4:0] CLS_GT      = 5'd12;
    localparam logic [4:0] CLS_GE      = 5'd13;
    localparam logic [4:0] CLS_LPAREN  = 5'd14;
    localparam logic [4:0] CLS_RPAREN  = 5'd15;
    localparam logic [4:0] CLS_COMMA   = 5'd16;
    localparam logic [4:0] CLS_SEMI    = 5'd17;
    localparam logic [4:0] CLS_PERIOD  = 5'd18;
    localparam logic [4:0] CLS_BECOMES = 5'd19;
    localparam logic [4:0] CLS_BEGIN   = 5'd20;
    localparam logic [4:0] CLS_END     = 5'd21;
    localparam logic [4:0] CLS_IF      = 5'd22;
    localparam logic [4:0] CLS_THEN    = 5'd23;
    localparam logic [4:0] CLS_WHILE   = 5'd24;
    localparam logic [4:0] CLS_WRITE   = 5'd25;
    localparam logic [4:0] CLS_READ    = 5'd26;
    localparam logic [4:0] CLS_DO      = 5'd27;
    localparam logic [4:0] CLS_CALL    = 5'd28;
    localparam logic [4:0] CLS_CONST   = 5'd29;
    localparam logic [4:0] CLS_VAR     = 5'd30;
    localparam logic [4:0] CLS_PROC    = 5'd31;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } char_word_t;

    typedef struct packed {
        logic [4:0]  token_class;
        logic [47:0] number_mantissa;
        logic [5:0]  fraction_digits;
        logic [9:0]  start_column;
        logic [10:0] token_length;
        logic [15:0] error_total;
        logic        last_of_burst;
    } token_word_t;

    // class lookup result
    typedef struct packed {
        logic       hit;
        logic [4:0] cls;
    } cls_hit_t;

    // work handed from front to back: up to two characters and a line flush
    typedef struct packed {
        logic        p1_v;
        logic [7:0]  p1_c;
        logic [15:0] p1_col;
        logic        p1_nxdig;
        logic        p1_pair_v;
        logic [4:0]  p1_pair_cls;
        logic        p2_v;
        logic [7:0]  p2_c;
        logic [15:0] p2_col;
        logic        eol;
    } entry_t;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
    endfunction

    // single operator characters; lone colon and equals are errors
    function automatic cls_hit_t op_class(input logic [7:0] c);
        cls_hit_t r;
        r.hit = 1'b1;
        unique case (c)
            CH_EQ, CH_COLON: r.cls = CLS_ERROR;
            CH_COMMA:        r.cls = CLS_COMMA;
            CH_GT:           r.cls = CLS_GT;
            CH_LT:           r.cls = CLS_LT;
            CH_SEMI:         r.cls = CLS_SEMI;
            CH_PLUS:         r.cls = CLS_PLUS;
            CH_MINUS:        r.cls = CLS_MINUS;
            CH_STAR:         r.cls = CLS_TIMES;
            CH_SLASH:        r.cls = CLS_SLASH;
            CH_LPAREN:       r.cls = CLS_LPAREN;
            CH_RPAREN:       r.cls = CLS_RPAREN;
            CH_HASH:         r.cls = CLS_HASH;
            default:
            begin
                r.hit = 1'b0;
                r.cls = CLS_ERROR;
            end
        endcase
        return r;
    endfunction

    // two-character operators
    function automatic cls_hit_t pair_class(input logic [7:0] a, input logic [7:0] b);
        cls_hit_t r;
        r.hit = (b == CH_EQ);
        unique case (a)
            CH_COLON: r.cls = CLS_BECOMES;
            CH_EQ:    r.cls = CLS_EQ;
            CH_GT:    r.cls = CLS_GE;
            CH_LT:    r.cls = CLS_LE;
            default:
            begin
                r.hit = 1'b0;
                r.cls = CLS_ERROR;
            end
        endcase
        return r;
    endfunction

    // keyword match; w holds the first nine characters, first one in the top byte
    function automatic cls_hit_t kw_lookup(input logic [71:0] w, input logic [3:0] n);
        cls_hit_t r;
        r.hit = 1'b1;
        if (n == 4'd3 && w[71:48] == "odd")            r.cls = CLS_ODD;
        else if (n == 4'd1 && w[71:64] == ".")         r.cls = CLS_PERIOD;
        else if (n == 4'd5 && w[71:32] == "begin")     r.cls = CLS_BEGIN;
        else if (n == 4'd3 && w[71:48] == "end")       r.cls = CLS_END;
        else if (n == 4'd2 && w[71:56] == "if")        r.cls = CLS_IF;
        else if (n == 4'd4 && w[71:40] == "then")      r.cls = CLS_THEN;
        else if (n == 4'd5 && w[71:32] == "while")     r.cls = CLS_WHILE;
        else if (n == 4'd5 && w[71:32] == "write")     r.cls = CLS_WRITE;
        else if (n == 4'd4 && w[71:40] == "read")      r.cls = CLS_READ;
        else if (n == 4'd2 && w[71:56] == "do")        r.cls = CLS_DO;
        else if (n == 4'd4 && w[71:40] == "call")      r.cls = CLS_CALL;
        else if (n == 4'd5 && w[71:32] == "const")     r.cls = CLS_CONST;
        else if (n == 4'd3 && w[71:48] == "var")       r.cls = CLS_VAR;
        else if (n == 4'd9 && w == "procedure")        r.cls = CLS_PROC;
        else
        begin
            r.hit = 1'b0;
            r.cls = CLS_ERROR;
        end
        return r;
    endfunction

endpackage

// File: rtl/stok_front.sv
// stok_front: takes character words, holds one back for lookahead, tracks the
// column and forms work entries for the back end. Depends on stok_pkg.
module stok_front #(
    parameter int LINE_MAX = stok_pkg::LINE_MAX_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_stall,
    input  stok_pkg::char_word_t char_word,
    output logic                 push,
    output stok_pkg::entry_t     entry,
    input  logic                 full
);

    localparam int CW = $clog2(LINE_MAX);

    logic [7:0]    held_reg, held_next;
    logic          held_v_reg, held_v_next;
    logic [CW-1:0] col_reg, col_next;

    logic                 acc;
    logic                 consumed;
    logic [CW-1:0]        col_a;
    stok_pkg::cls_hit_t   pr;

    function automatic logic [CW-1:0] nc(input logic [CW-1:0] x);
        nc = (x != CW'(LINE_MAX - 1)) ? x + 1'b1 : x;
    endfunction

    assign char_stall = full;
    assign acc        = char_valid && !char_stall;

    // pair detection and column after the held character
    always_comb
    begin
        pr       = stok_pkg::pair_class(held_reg, char_word.char_code);
        consumed = held_v_reg && pr.hit;
        if (!held_v_reg)
            col_a = col_reg;
        else if (consumed)
            col_a = nc(nc(col_reg));
        else
            col_a = nc(col_reg);
    end

    // entry for the back end
    always_comb
    begin
        entry.p1_v        = held_v_reg;
        entry.p1_c        = held_reg;
        entry.p1_col      = 16'(col_reg);
        entry.p1_nxdig    = stok_pkg::is_digit(char_word.char_code);
        entry.p1_pair_v   = consumed;
        entry.p1_pair_cls = pr.cls;
        entry.p2_v        = !consumed && char_word.line_end;
        entry.p2_c        = char_word.char_code;
        entry.p2_col      = 16'(col_a);
        entry.eol         = char_word.line_end;
        push              = acc && (held_v_reg || char_word.line_end);
    end

    // held character and column update
    always_comb
    begin
        held_next   = held_reg;
        held_v_next = held_v_reg;
        col_next    = col_reg;
        if (acc)
        begin
            if (char_word.line_end)
            begin
                held_v_next = 1'b0;
                col_next    = '0;
            end
            else
            begin
                col_next    = col_a;
                held_v_next = !consumed;
                if (!consumed)
                    held_next = char_word.char_code;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            held_v_reg <= 1'b0;
            col_reg    <= '0;
        end
        else
        begin
            held_reg   <= held_next;
            held_v_reg <= held_v_next;
            col_reg    <= col_next;
        end
    end

endmodule

// File: rtl/stok_queue.sv
// stok_queue: short register queue of work entries between front and back.
// Depends on stok_pkg for the entry type.
module stok_queue #(
    parameter int DEPTH = stok_pkg::QDEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  stok_pkg::entry_t wr_data,
    input  logic             pop,
    output stok_pkg::entry_t rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    stok_pkg::entry_t mem_reg [DEPTH];
    logic [PW-1:0]    wp_reg, wp_next, rp_reg, rp_next;
    logic [NW-1:0]    cnt_reg, cnt_next;

    function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
        inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full    = (cnt_reg == NW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rp_reg];

    // pointer and fill count
    always_comb
    begin
        wp_next  = push ? inc(wp_reg) : wp_reg;
        rp_next  = pop ? inc(rp_reg) : rp_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

// File: rtl/stok_back.sv
// stok_back: runs queued work entries step by step: word building, number
// accumulation, keyword classing and token output. Depends on stok_pkg.
module stok_back #(
    parameter int WORD_BUF = stok_pkg::WORD_BUF_DEF,
    parameter int LINE_MAX = stok_pkg::LINE_MAX_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stok_pkg::entry_t      entry,
    input  logic                  empty,
    output logic                  pop,
    output logic                  token_valid,
    input  logic                  token_stall,
    output stok_pkg::token_word_t token_word
);

    localparam int CW = $clog2(LINE_MAX);
    localparam int NW = $clog2(LINE_MAX + 1);
    localparam int BW = $clog2(WORD_BUF);

    typedef enum logic [2:0] {
        ST_NEW,
        ST_P1_PRE,
        ST_P1_MAIN,
        ST_P2_PRE,
        ST_P2_MAIN,
        ST_FLUSH
    } step_t;

    step_t         stp_reg, stp_next;
    logic [NW-1:0] wc_reg, wc_next;
    logic [CW-1:0] ws_reg, ws_next;
    logic [3:0]    fl_reg, fl_next;
    logic [47:0]   dv_reg, dv_next;
    logic [5:0]    dd_reg, dd_next;
    logic [15:0]   err_reg, err_next;
    logic [7:0]    ch_reg [WORD_BUF];
    stok_pkg::token_word_t tok_reg, tok_next, out_reg, out_next;
    logic          tok_v_reg, tok_v_next, tok_fin_reg, tok_fin_next;
    logic          ov_reg, ov_next;

    step_t         cur, after, nstep;
    logic          is_p1;
    logic [7:0]    pc;
    logic [15:0]   pcol;
    logic          pnx, ppv;
    logic [4:0]    ppc;
    logic          blank, dot, dg, lt, join_dot, need_flush;
    stok_pkg::cls_hit_t oc, kw;
    logic          do_flush, do_main, do_op, do_app;
    logic          adv, done;
    logic [71:0]   w72;
    logic [3:0]    len4;
    logic [31:0]   ws_ext, wc_ext;
    stok_pkg::token_word_t wt, ot, t;
    logic          t_v;
    logic [47:0]   acc_base;
    logic [51:0]   prod;
    logic [47:0]   acc_val;
    logic          ch_we;

    assign adv         = !ov_reg || !token_stall;
    assign token_valid = ov_reg;
    assign token_word  = out_reg;

    // current step and the character it works on
    always_comb
    begin
        if (stp_reg == ST_NEW)
            cur = entry.p1_v ? ST_P1_PRE : (entry.p2_v ? ST_P2_PRE : ST_FLUSH);
        else
            cur = stp_reg;
        is_p1 = (cur == ST_P1_PRE) || (cur == ST_P1_MAIN);
        pc    = is_p1 ? entry.p1_c : entry.p2_c;
        pcol  = is_p1 ? entry.p1_col : entry.p2_col;
        pnx   = is_p1 && entry.p1_nxdig;
        ppv   = is_p1 && entry.p1_pair_v;
        ppc   = entry.p1_pair_cls;
        if (is_p1)
            after = entry.p2_v ? ST_P2_PRE : (entry.eol ? ST_FLUSH : ST_NEW);
        else
            after = entry.eol ? ST_FLUSH : ST_NEW;
    end

    // character classing
    always_comb
    begin
        blank = (pc == stok_pkg::CH_SPACE) || (pc == stok_pkg::CH_TAB)
             || (pc == stok_pkg::CH_LF);
        dot   = (pc == stok_pkg::CH_DOT);
        dg    = stok_pkg::is_digit(pc);
        lt    = stok_pkg::is_letter(pc);
        oc    = stok_pkg::op_class(pc);
        join_dot   = (wc_reg != '0) && fl_reg[stok_pkg::FL_LASTDIG] && pnx;
        need_flush = (wc_reg != '0) && (blank || oc.hit || (dot && !join_dot));
    end

    // finished word token
    always_comb
    begin
        for (int i = 0; i < 9; i++)
            w72[71 - 8 * i -: 8] = ch_reg[i];
        len4   = (wc_reg < NW'(10)) ? wc_reg[3:0] : 4'd0;
        kw     = stok_pkg::kw_lookup(w72, len4);
        ws_ext = 32'(ws_reg);
        wc_ext = 32'(wc_reg);
        wt     = '0;
        wt.start_column = ws_ext[9:0];
        wt.token_length = wc_ext[10:0];
        if (kw.hit)
            wt.token_class = kw.cls;
        else if (fl_reg[stok_pkg::FL_ID])
            wt.token_class = stok_pkg::CLS_IDENT;
        else if (fl_reg[stok_pkg::FL_NUM])
        begin
            wt.token_class     = stok_pkg::CLS_NUMBER;
            wt.number_mantissa = dv_reg;
            wt.fraction_digits = dd_reg;
        end
        else
            wt.token_class = stok_pkg::CLS_ERROR;
    end

    // operator token
    always_comb
    begin
        ot              = '0;
        ot.token_class  = ppv ? ppc : oc.cls;
        ot.start_column = pcol[9:0];
        ot.token_length = ppv ? 11'd2 : 11'd1;
    end

    // decimal accumulate, saturating
    always_comb
    begin
        acc_base = (wc_reg == '0) ? '0 : dv_reg;
        prod     = (52'(acc_base) << 3) + (52'(acc_base) << 1) + 52'(pc[3:0]);
        acc_val  = (prod > 52'(stok_pkg::MANT_MAX)) ? stok_pkg::MANT_MAX : prod[47:0];
    end

    // step decode
    always_comb
    begin
        do_flush = 1'b0;
        do_main  = 1'b0;
        nstep    = ST_NEW;
        unique case (cur)
            ST_P1_PRE, ST_P2_PRE:
            begin
                if (need_flush)
                begin
                    do_flush = 1'b1;
                    nstep    = (cur == ST_P1_PRE) ? ST_P1_MAIN : ST_P2_MAIN;
                end
                else
                begin
                    do_main = 1'b1;
                    nstep   = after;
                end
            end
            ST_P1_MAIN, ST_P2_MAIN:
            begin
                do_main = 1'b1;
                nstep   = after;
            end
            ST_FLUSH:
            begin
                do_flush = (wc_reg != '0);
                nstep    = ST_NEW;
            end
            default:
                nstep = ST_NEW;
        endcase
        do_op = do_main && oc.hit;
        do_app = do_main && !oc.hit && !blank;
        done  = (nstep == ST_NEW);
        t_v   = do_flush || do_op;
        t     = do_flush ? wt : ot;
    end

    // word state, error count and output staging
    always_comb
    begin
        stp_next     = stp_reg;
        wc_next      = wc_reg;
        ws_next      = ws_reg;
        fl_next      = fl_reg;
        dv_next      = dv_reg;
        dd_next      = dd_reg;
        err_next     = err_reg;
        tok_next     = tok_reg;
        tok_v_next   = tok_v_reg;
        tok_fin_next = tok_fin_reg;
        out_next     = out_reg;
        ov_next      = ov_reg && token_stall;
        pop          = 1'b0;
        ch_we        = 1'b0;
        if (adv)
        begin
            if (tok_v_reg && tok_fin_reg)
            begin
                // last token of the entry goes out on its own
                out_next               = tok_reg;
                out_next.last_of_burst = 1'b1;
                ov_next                = 1'b1;
                tok_v_next             = 1'b0;
                tok_fin_next           = 1'b0;
            end
            else if (!empty)
            begin
                stp_next = nstep;
                pop      = done;
                if (do_flush)
                begin
                    wc_next = '0;
                    fl_next = '0;
                    dv_next = '0;
                    dd_next = '0;
                end
                if (do_app)
                begin
                    ch_we = (wc_reg < NW'(WORD_BUF));
                    if (wc_reg < NW'(LINE_MAX))
                        wc_next = wc_reg + 1'b1;
                    if (wc_reg == '0)
                    begin
                        ws_next = pcol[CW-1:0];
                        fl_next = '0;
                        fl_next[stok_pkg::FL_ID]  = lt;
                        fl_next[stok_pkg::FL_NUM] = dg;
                        dv_next = dg ? acc_val : '0;
                        dd_next = '0;
                    end
                    else
                    begin
                        if (!(lt || dg || pc == stok_pkg::CH_UNDER))
                            fl_next[stok_pkg::FL_ID] = 1'b0;
                        if (fl_reg[stok_pkg::FL_NUM])
                        begin
                            if (fl_reg[stok_pkg::FL_DOT])
                            begin
                                if (dg)
                                begin
                                    dv_next = acc_val;
                                    if (dd_reg != stok_pkg::FRAC_MAX)
                                        dd_next = dd_reg + 1'b1;
                                end
                                else
                                    fl_next[stok_pkg::FL_NUM] = 1'b0;
                            end
                            else if (dot)
                                fl_next[stok_pkg::FL_DOT] = 1'b1;
                            else if (dg)
                                dv_next = acc_val;
                            else
                                fl_next[stok_pkg::FL_NUM] = 1'b0;
                        end
                    end
                    fl_next[stok_pkg::FL_LASTDIG] = dg;
                end
                if (t_v)
                begin
                    if (t.token_class == stok_pkg::CLS_ERROR && err_reg != 16'(stok_pkg::ERR_MAX))
                        err_next = err_reg + 1'b1;
                    if (tok_v_reg)
                    begin
                        out_next               = tok_reg;
                        out_next.last_of_burst = 1'b0;
                        ov_next                = 1'b1;
                    end
                    tok_next             = t;
                    tok_next.error_total = err_next;
                    tok_v_next           = 1'b1;
                    tok_fin_next         = done;
                end
                else if (done && tok_v_reg)
                begin
                    out_next               = tok_reg;
                    out_next.last_of_burst = 1'b1;
                    ov_next                = 1'b1;
                    tok_v_next             = 1'b0;
                    tok_fin_next           = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stp_reg     <= ST_NEW;
            wc_reg      <= '0;
            ws_reg      <= '0;
            fl_reg      <= '0;
            dv_reg      <= '0;
            dd_reg      <= '0;
            err_reg     <= '0;
            tok_v_reg   <= 1'b0;
            tok_fin_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            stp_reg     <= stp_next;
            wc_reg      <= wc_next;
            ws_reg      <= ws_next;
            fl_reg      <= fl_next;
            dv_reg      <= dv_next;
            dd_reg      <= dd_next;
            err_reg     <= err_next;
            tok_v_reg   <= tok_v_next;
            tok_fin_reg <= tok_fin_next;
            ov_reg      <= ov_next;
        end
    end

    // token payload and word characters
    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        out_reg <= out_next;
        if (ch_we)
            ch_reg[wc_reg[BW-1:0]] <= pc;
    end

`ifndef SYNTHESIS
    a_fin_has_tok: assert property (@(posedge clk) disable iff (!rst_n)
        tok_fin_reg |-> tok_v_reg)
        else $error("final mark without a staged token");
    a_err_mono: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg >= $past(err_reg))
        else $error("error count went down");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");
    a_empty_word_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (wc_reg == '0) |-> (fl_reg == '0))
        else $error("flags left over in empty word");
`endif

endmodule

// File: rtl/source_tokenizer_core.sv
// source_tokenizer_core: top level of the source tokenizer.
// Depends on stok_pkg, stok_front, stok_queue and stok_back.
//
// Usage: characters of a source line arrive one per word on the char channel
// (char_valid / char_stall / char_word), with line_end set on the line's last
// character. Tokens leave on the token channel (token_valid / token_stall /
// token_word), one per word, last_of_burst marking the final token caused by
// one character. A character is held back until the next one arrives (one
// character of lookahead), so a token appears once the character after it
// is accepted, or at the line end; it then passes through the queue, the step
// unit and the output register.
// Throughput: one character per cycle while the step unit keeps up. The step
// unit runs one step per cycle while the output is not stalled and stages at most
// one token per step: a word ended by an operator takes two steps, a line end
// adds a flush step, and the last token of a character goes out on its own.
// A four-entry queue parts the character intake from the step unit.
// When token_stall is high the output register and staging token hold, the
// queue fills and char_stall rises. Reset clears the held character, column,
// word state, error count and all valid flags; no clearing pass is needed.
module source_tokenizer_core #(
    parameter int WORD_BUF = stok_pkg::WORD_BUF_DEF,
    parameter int LINE_MAX = stok_pkg::LINE_MAX_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    output logic                  char_stall,
    input  stok_pkg::char_word_t  char_word,
    output logic                  token_valid,
    input  logic                  token_stall,
    output stok_pkg::token_word_t token_word
);

    stok_pkg::entry_t wr_entry, rd_entry;
    logic             push, pop, full, empty;

    // intake and lookahead
    stok_front #(
        .LINE_MAX (LINE_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word),
        .push       (push),
        .entry      (wr_entry),
        .full       (full)
    );

    // work queue
    stok_queue #(
        .DEPTH (stok_pkg::QDEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_entry),
        .pop     (pop),
        .rd_data (rd_entry),
        .full    (full),
        .empty   (empty)
    );

    // step unit and token output
    stok_back #(
        .WORD_BUF (WORD_BUF),
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry       (rd_entry),
        .empty       (empty),
        .pop         (pop),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_word  (token_word)
    );

endmodule

// File: bench/tb_source_tokenizer_core.sv
// tb_source_tokenizer_core: self-checking bench for the source tokenizer core.
// Depends on stok_pkg and source_tokenizer_core; predicts tokens per character
// word and compares every token word field by field.
module tb_source_tokenizer_core;

    localparam int WBUF    = 16;
    localparam int LMAX    = 1024;
    localparam int LIMIT   = 400000;
    localparam logic [3:0] F_ID = 4'b0001;
    localparam logic [3:0] F_NUM = 4'b0010;
    localparam logic [3:0] F_DOT = 4'b0100;
    localparam logic [3:0] F_LD = 4'b1000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  char_valid = 1'b0;
    logic                  char_stall;
    stok_pkg::char_word_t  char_word = '0;
    logic                  token_valid;
    logic                  token_stall = 1'b0;
    stok_pkg::token_word_t token_word;

    source_tokenizer_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .char_valid(char_valid), .char_stall(char_stall), .char_word(char_word),
        .token_valid(token_valid), .token_stall(token_stall), .token_word(token_word)
    );

    always #2 clk = ~clk;

    // tokenizer shadow state
    logic [7:0]  lex_chars [WBUF];
    int          lex_count, lex_start, lex_col;
    logic [7:0]  lex_held;
    bit          lex_held_v;
    logic [47:0] lex_mant;
    int          lex_frac;
    logic [3:0]  lex_flags;
    int          lex_errs;
    stok_pkg::token_word_t burst [$];
    stok_pkg::token_word_t expected_tokens [$];

    int   fail_count = 0;
    int   cycle_count = 0;
    int   stall_left = 0;
    bit   hold_long = 1'b0;

    function automatic bit dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic int single_op(logic [7:0] c);
        case (c)
            "=", ":": return stok_pkg::CLS_ERROR;
            ",": return stok_pkg::CLS_COMMA;
            ">": return stok_pkg::CLS_GT;
            "<": return stok_pkg::CLS_LT;
            ";": return stok_pkg::CLS_SEMI;
            "+": return stok_pkg::CLS_PLUS;
            "-": return stok_pkg::CLS_MINUS;
            "*": return stok_pkg::CLS_TIMES;
            "/": return stok_pkg::CLS_SLASH;
            "(": return stok_pkg::CLS_LPAREN;
            ")": return stok_pkg::CLS_RPAREN;
            "#": return stok_pkg::CLS_HASH;
            default: return -1;
        endcase
    endfunction

    function automatic int double_op(logic [7:0] a, logic [7:0] b);
        if (b != "=") return -1;
        case (a)
            ":": return stok_pkg::CLS_BECOMES;
            "=": return stok_pkg::CLS_EQ;
            ">": return stok_pkg::CLS_GE;
            "<": return stok_pkg::CLS_LE;
            default: return -1;
        endcase
    endfunction

    task automatic push_token(int cls, logic [47:0] m, int f, int st, int len);
        stok_pkg::token_word_t t;
        if (burst.size() >= 3) return;
        if (cls == stok_pkg::CLS_ERROR && lex_errs < 16'hFFFF) lex_errs++;
        t.token_class = cls[4:0];
        t.number_mantissa = m;
        t.fraction_digits = f[5:0];
        t.start_column = st[9:0];
        t.token_length = len[10:0];
        t.error_total = lex_errs[15:0];
        t.last_of_burst = 1'b0;
        burst.push_back(t);
    endtask

    function automatic int keyword_class();
        string kw [14] = '{"odd", ".", "begin", "end", "if", "then", "while", "write",
                           "read", "do", "call", "const", "var", "procedure"};
        int    kc [14] = '{stok_pkg::CLS_ODD, stok_pkg::CLS_PERIOD, stok_pkg::CLS_BEGIN,
                           stok_pkg::CLS_END, stok_pkg::CLS_IF, stok_pkg::CLS_THEN,
                           stok_pkg::CLS_WHILE, stok_pkg::CLS_WRITE, stok_pkg::CLS_READ,
                           stok_pkg::CLS_DO, stok_pkg::CLS_CALL, stok_pkg::CLS_CONST,
                           stok_pkg::CLS_VAR, stok_pkg::CLS_PROC};
        bit    ok;
        for (int i = 0; i < 14; i++)
        begin
            if (kw[i].len() == lex_count)
            begin
                ok = 1'b1;
                for (int j = 0; j < lex_count; j++)
                    if (lex_chars[j] != kw[i][j]) ok = 1'b0;
                if (ok) return kc[i];
            end
        end
        return -1;
    endfunction

    task automatic flush_word();
        int k;
        if (lex_count == 0) return;
        k = keyword_class();
        if (k >= 0) push_token(k, 0, 0, lex_start, lex_count);
        else if (lex_flags & F_ID)
            push_token(stok_pkg::CLS_IDENT, 0, 0, lex_start, lex_count);
        else if (lex_flags & F_NUM)
            push_token(stok_pkg::CLS_NUMBER, lex_mant, lex_frac, lex_start, lex_count);
        else push_token(stok_pkg::CLS_ERROR, 0, 0, lex_start, lex_count);
        lex_count = 0;
        lex_flags = '0;
        lex_mant = '0;
        lex_frac = 0;
    endtask

    task automatic add_digit(logic [7:0] c);
        logic [47:0] d;
        d = 48'(c - "0");
        if (lex_mant > (stok_pkg::MANT_MAX - d) / 10) lex_mant = stok_pkg::MANT_MAX;
        else lex_mant = lex_mant * 10 + d;
    endtask

    task automatic append_char(logic [7:0] c, int col);
        bit d;
        d = dig(c);
        if (lex_count == 0)
        begin
            lex_start = col;
            lex_flags = (alpha(c) ? F_ID : 4'b0) | (d ? F_NUM : 4'b0);
            lex_mant = '0;
            lex_frac = 0;
            if (d) add_digit(c);
        end
        else
        begin
            if (!(alpha(c) || d || c == "_")) lex_flags &= ~F_ID;
            if (lex_flags & F_NUM)
            begin
                if (lex_flags & F_DOT)
                begin
                    if (d)
                    begin
                        add_digit(c);
                        if (lex_frac < 63) lex_frac++;
                    end
                    else lex_flags &= ~F_NUM;
                end
                else if (c == ".") lex_flags |= F_DOT;
                else if (d) add_digit(c);
                else lex_flags &= ~F_NUM;
            end
        end
        if (d) lex_flags |= F_LD;
        else lex_flags &= ~F_LD;
        if (lex_count < WBUF) lex_chars[lex_count] = c;
        if (lex_count < LMAX) lex_count++;
    endtask

    // one character with optional lookahead; returns 1 when the lookahead is used
    task automatic scan_char(logic [7:0] c, int col, bit has_nx, logic [7:0] nx,
                             output bit used);
        int oc, pc;
        used = 1'b0;
        if (c == " " || c == 8'h09 || c == 8'h0A)
        begin
            flush_word();
            return;
        end
        oc = single_op(c);
        if (oc >= 0)
        begin
            pc = has_nx ? double_op(c, nx) : -1;
            flush_word();
            if (pc >= 0)
            begin
                push_token(pc, 0, 0, col, 2);
                used = 1'b1;
            end
            else push_token(oc, 0, 0, col, 1);
            return;
        end
        if (c == ".")
        begin
            if (!(lex_count != 0 && (lex_flags & F_LD) && has_nx && dig(nx))) flush_word();
            append_char(c, col);
            return;
        end
        append_char(c, col);
    endtask

    function automatic int step_col(int col);
        return col < LMAX - 1 ? col + 1 : col;
    endfunction

    task automatic predict_tokens(stok_pkg::char_word_t w);
        bit used, dummy;
        used = 1'b0;
        burst.delete();
        if (lex_held_v)
        begin
            scan_char(lex_held, lex_col, 1'b1, w.char_code, used);
            lex_held_v = 1'b0;
            lex_col = step_col(lex_col);
            if (used) lex_col = step_col(lex_col);
        end
        if (!used)
        begin
            if (w.line_end)
            begin
                scan_char(w.char_code, lex_col, 1'b0, 8'h00, dummy);
                lex_col = step_col(lex_col);
            end
            else
            begin
                lex_held = w.char_code;
                lex_held_v = 1'b1;
            end
        end
        if (w.line_end)
        begin
            flush_word();
            lex_col = 0;
            lex_held_v = 1'b0;
        end
        if (burst.size() > 0) burst[burst.size() - 1].last_of_burst = 1'b1;
        foreach (burst[i]) expected_tokens.push_back(burst[i]);
    endtask

    function automatic int short_gap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30)
             : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 2) : 0);
    endfunction

    // send one character word, predicting on acceptance; valid stays high
    // into the next word unless a gap follows
    task automatic send_char(logic [7:0] c, bit last, bit gaps = 1'b1);
        int g;
        g = gaps ? short_gap() : 0;
        if (g > 0)
        begin
            char_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        char_word.char_code <= c;
        char_word.line_end <= last;
        char_valid <= 1'b1;
        do @(posedge clk); while (char_stall);
        predict_tokens('{char_code: c, line_end: last});
        @(negedge clk);
    endtask

    task automatic send_line(string s, bit gaps = 1'b1);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1, gaps);
    endtask

    task automatic wait_drained();
        char_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // receiver stall pattern: mostly short holds, a few long ones
    always @(negedge clk)
    begin
        if (hold_long)
            token_stall <= 1'b1;
        else if (stall_left > 0)
        begin
            token_stall <= 1'b1;
            stall_left--;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            token_stall <= 1'b1;
            stall_left = short_gap();
        end
        else
            token_stall <= 1'b0;
    end

    // token checker
    always @(posedge clk)
    begin
        stok_pkg::token_word_t e;
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("%0t timeout", $time);
            $display("*** FAILED ***");
            $finish;
        end
        if (rst_n && token_valid && !token_stall)
        begin
            if (expected_tokens.size() == 0)
            begin
                $display("%0t unexpected token: expected none actual %p", $time, token_word);
                fail_count++;
            end
            else
            begin
                e = expected_tokens.pop_front();
                if (e.token_class !== token_word.token_class)
                    $display("%0t class: expected %0d actual %0d", $time,
                             e.token_class, token_word.token_class);
                if (e.number_mantissa !== token_word.number_mantissa)
                    $display("%0t mantissa: expected %0d actual %0d", $time,
                             e.number_mantissa, token_word.number_mantissa);
                if (e.fraction_digits !== token_word.fraction_digits)
                    $display("%0t fraction: expected %0d actual %0d", $time,
                             e.fraction_digits, token_word.fraction_digits);
                if (e.start_column !== token_word.start_column)
                    $display("%0t column: expected %0d actual %0d", $time,
                             e.start_column, token_word.start_column);
                if (e.token_length !== token_word.token_length)
                    $display("%0t length: expected %0d actual %0d", $time,
                             e.token_length, token_word.token_length);
                if (e.error_total !== token_word.error_total)
                    $display("%0t errors: expected %0d actual %0d", $time,
                             e.error_total, token_word.error_total);
                if (e.last_of_burst !== token_word.last_of_burst)
                    $display("%0t last: expected %0d actual %0d", $time,
                             e.last_of_burst, token_word.last_of_burst);
                if (e !== token_word) fail_count++;
            end
        end
    end

    // keywords, numbers, operators, pairs, lone colon/equals and odd bytes
    task automatic test_directed();
        send_line("begin x:=12.50; end.");
        send_line("odd a==b # c>=d<=e<f>g : = ,()+-*/");
        send_line("number indent procedure const call var while write");
        send_line("read if then do 3.x 4. .5 a_1 1a");
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h0A, 1'b0);
        send_char(8'h09, 1'b1);
        send_char("=", 1'b1);
        send_char(":", 1'b0);
        send_char("=", 1'b1);
    endtask

    // saturating mantissa, fraction count and a word longer than the buffer
    task automatic test_saturation();
        string s;
        s = "";
        for (int i = 0; i < 16; i++) s = {s, "9"};
        s = {s, "."};
        for (int i = 0; i < 64; i++) s = {s, "1"};
        send_line(s, 1'b0);
        s = "";
        for (int i = 0; i < 20; i++) s = {s, "q"};
        send_line({s, " +"}, 1'b0);
    endtask

    function automatic logic [7:0] pick_char();
        string pool = "abcdefghijklmnopqrstuvwxyzXY_0123456789.:=<>#;,+-*/() \t";
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(0, 255));
            default: return pool[$urandom_range(0, pool.len() - 1)];
        endcase
    endfunction

    function automatic string pick_piece();
        string pieces [16] = '{"begin", "end", "odd", "while", "procedure", "x1", "3.14",
                               "007", ":=", "==", ">=", "<=", "call", "const", "var", "do"};
        return pieces[$urandom_range(0, 15)];
    endfunction

    // random lines, mostly well-formed token sequences
    task automatic test_random();
        string s;
        int    sent;
        sent = 0;
        while (sent < 16)
        begin
            s = "";
            if ($urandom_range(0, 3) != 0)
            begin
                repeat ($urandom_range(1, 5))
                    s = {s, pick_piece(), ($urandom_range(0, 1) ? " " : "")};
            end
            else
            begin
                repeat ($urandom_range(1, 12))
                begin
                    s = {s, " "};
                    s[s.len() - 1] = pick_char();
                end
            end
            send_line(s);
            sent += s.len();
        end
    endtask

    // long receiver hold while characters keep coming, then a sender pause
    task automatic test_backpressure();
        fork
            begin
                hold_long = 1'b1;
                for (int n = 0; n < 200; n++) @(posedge clk);
                hold_long = 1'b0;
            end
            send_line("a+b;c+d;e+f;g", 1'b0);
        join
        wait_drained();
        send_line("end.");
    endtask

    initial
    begin
        lex_count = 0; lex_start = 0; lex_col = 0; lex_held = '0; lex_held_v = 0;
        lex_mant = '0; lex_frac = 0; lex_flags = '0; lex_errs = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_saturation();
        test_backpressure();
        test_random();
        wait_drained();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
